// ===== hw/rtl/puewe_pkg.sv =====
// ----------------------------------------------------------------------------
// puewe_pkg
// Shared types, constants and codes for the per-user event window block.
// ----------------------------------------------------------------------------
package puewe_pkg;

    localparam int UserSlotsDef    = 64;
    localparam int HistoryDepthDef = 32;

    localparam int ModeW   = 3;
    localparam int UserW   = 6;
    localparam int ZoneW   = 16;
    localparam int TimeW   = 32;
    localparam int WinW    = 16;
    localparam int CapW    = 6;
    localparam int CntW    = 6;
    localparam int TotW    = 7;
    localparam int CfgIdxW = 1;

    localparam int InDataW  = 56;
    localparam int InUserW  = ModeW;
    localparam int OutDataW = 40;
    localparam int OutUserW = 1;

    localparam logic [WinW-1:0] WindowReset = 16'd300;
    localparam logic [CapW-1:0] CapReset    = 6'd32;

    localparam logic [CfgIdxW-1:0] CfgWindow = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgCap    = 1'b1;

    localparam logic [ModeW-1:0] ModeAdd      = 3'd0;
    localparam logic [ModeW-1:0] ModeSweep    = 3'd1;
    localparam logic [ModeW-1:0] ModeRmEmpty  = 3'd2;
    localparam logic [ModeW-1:0] ModeRmUser   = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_FINISH,
        ST_STATUS
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic apply;     // present mark, trim and push or erase
        logic rd_front;  // read front event of the ring
        logic pop;       // drop front event and present report
        logic finish;    // sweep erase check
        logic status;    // present status
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic can_expire;  // ring not empty and front event too old
        logic do_expire;   // mode expires events
    } dp_stat_t;

endpackage

// ===== hw/rtl/puewe_ctrl.sv =====
// ----------------------------------------------------------------------------
// puewe_ctrl
// Sequencer for one transaction: lookup, update, expiry loop, status.
// ----------------------------------------------------------------------------
module puewe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output puewe_pkg::ctrl_cmd_t  cmd,
    input  puewe_pkg::dp_stat_t   stat
);
    import puewe_pkg::*;

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.apply  = 1'b1;
                state_next = stat.do_expire ? ST_READ : ST_STATUS;
            end
            ST_READ: begin
                cmd.rd_front = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = stat.can_expire ? ST_EMIT : ST_FINISH;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_STATUS;
            end
            ST_STATUS: begin
                out_valid  = 1'b1;
                cmd.status = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/puewe_dp.sv =====
// ----------------------------------------------------------------------------
// puewe_dp
// Per-user ring state, event memories and result formatting.
// ----------------------------------------------------------------------------
module puewe_dp #(
    parameter int USER_SLOTS    = puewe_pkg::UserSlotsDef,
    parameter int HISTORY_DEPTH = puewe_pkg::HistoryDepthDef
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [puewe_pkg::InDataW-1:0]    in_data,
    input  logic [puewe_pkg::InUserW-1:0]    in_mode,
    input  logic                             cfg_we,
    input  logic [puewe_pkg::CfgIdxW-1:0]    cfg_idx,
    input  logic [puewe_pkg::WinW-1:0]       cfg_data,
    input  puewe_pkg::ctrl_cmd_t             cmd,
    output puewe_pkg::dp_stat_t              stat,
    output logic [puewe_pkg::OutDataW-1:0]   out_data,
    output logic [puewe_pkg::OutUserW-1:0]   out_kind,
    output logic                             out_last
);
    import puewe_pkg::*;

    localparam int SlotW  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
    localparam int PosW   = $clog2(HISTORY_DEPTH);
    localparam int RCntW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SumW   = RCntW + 1;
    localparam int AddrW  = SlotW + PosW;
    localparam int MemD   = USER_SLOTS << PosW;
    localparam int RingW  = PosW + RCntW;

    // ring position plus step, wrapped at the history depth
    function automatic logic [PosW-1:0] wrap_add(input logic [PosW-1:0]  base,
                                                 input logic [RCntW-1:0] step);
        logic [SumW-1:0] sum;
        sum = SumW'(base) + SumW'(step);
        if (sum >= SumW'(HISTORY_DEPTH)) begin
            sum = sum - SumW'(HISTORY_DEPTH);
        end
        return PosW'(sum);
    endfunction

    // configuration registers
    logic [WinW-1:0] window_reg;
    logic [CapW-1:0] cap_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WindowReset;
            cap_reg    <= CapReset;
        end else if (cfg_we) begin
            case (cfg_idx)
                CfgWindow: window_reg <= cfg_data;
                CfgCap:    cap_reg    <= cfg_data[CapW-1:0];
                default:   ;
            endcase
        end
    end

    // present flags in flip-flops, ring pointers in a small memory
    logic [USER_SLOTS-1:0]  present_reg;
    logic [TotW-1:0]        total_reg;
    logic [RingW-1:0]       ring_mem [USER_SLOTS];
    logic [RingW-1:0]       ring_rd_reg;
    logic [PosW-1:0]        work_head_reg, work_head_next;
    logic [RCntW-1:0]       work_count_reg, work_count_next;
    logic                   ring_we;

    // event memories
    logic [ZoneW-1:0] zone_mem [MemD];
    logic [TimeW-1:0] time_mem [MemD];
    logic [ZoneW-1:0] rd_zone_reg;
    logic [TimeW-1:0] rd_time_reg;

    // captured transaction
    logic [ModeW-1:0] mode_reg;
    logic [UserW-1:0] user_reg;
    logic [ZoneW-1:0] zin_reg;
    logic [TimeW-1:0] now_reg;
    logic             removed_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            user_reg <= in_data[UserW-1:0];
            zin_reg  <= in_data[UserW +: ZoneW];
            now_reg  <= in_data[UserW+ZoneW +: TimeW];
        end
    end

    // slot decode
    logic             in_range;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] in_slot;
    assign in_range = ({{(32-UserW){1'b0}}, user_reg} < 32'(USER_SLOTS));
    assign slot     = SlotW'(user_reg);
    assign in_slot  = SlotW'(in_data[UserW-1:0]);

    // pointers of an absent user read as an empty ring at position zero
    logic             cur_present;
    logic [PosW-1:0]  base_head;
    logic [RCntW-1:0] base_count;
    logic [PosW-1:0]  cur_head;
    logic [RCntW-1:0] cur_count;
    assign cur_present = present_reg[slot];
    assign base_head   = cur_present ? ring_rd_reg[RCntW +: PosW] : '0;
    assign base_count  = cur_present ? ring_rd_reg[RCntW-1:0] : '0;
    assign cur_head    = cmd.apply ? base_head  : work_head_reg;
    assign cur_count   = cmd.apply ? base_count : work_count_reg;

    // effective cap, clamped to 1..HISTORY_DEPTH
    logic [RCntW-1:0] cap_eff;
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = RCntW'(1);
        end else if ({26'd0, cap_reg} > 32'(HISTORY_DEPTH)) begin
            cap_eff = RCntW'(HISTORY_DEPTH);
        end else begin
            cap_eff = RCntW'(cap_reg);
        end
    end

    // trimming for add: drop oldest until count is cap-1
    logic [RCntW-1:0] drop_n, add_count;
    logic [PosW-1:0]  add_head, push_pos;
    logic [AddrW-1:0] push_addr;
    always_comb begin
        drop_n    = (cur_count >= cap_eff) ? RCntW'(cur_count - cap_eff + 1'b1) : '0;
        add_head  = wrap_add(cur_head, drop_n);
        add_count = cur_count - drop_n;
        push_pos  = wrap_add(add_head, add_count);
        push_addr = {slot, push_pos};
    end

    logic is_add;
    assign is_add = (mode_reg == ModeAdd);
    assign stat.do_expire = in_range && (is_add || (mode_reg == ModeSweep && cur_present));

    // front address
    logic [AddrW-1:0] front_addr;
    assign front_addr = {slot, cur_head};

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.apply && in_range && is_add) begin
            zone_mem[push_addr] <= zin_reg;
            time_mem[push_addr] <= now_reg;
        end
        if (cmd.rd_front) begin
            rd_zone_reg <= zone_mem[front_addr];
            rd_time_reg <= time_mem[front_addr];
        end
    end

    // expiry test of front event
    logic [TimeW-1:0] age;
    assign age = now_reg - rd_time_reg;
    assign stat.can_expire = (cur_count != '0) && (age > {16'd0, window_reg});

    // erase decision
    logic do_erase;
    always_comb begin
        do_erase = 1'b0;
        if (in_range) begin
            if (cmd.apply) begin
                do_erase = (mode_reg == ModeRmUser) ||
                           (mode_reg == ModeRmEmpty && cur_present && cur_count == '0);
            end
            if (cmd.finish) begin
                do_erase = (mode_reg == ModeSweep) && cur_present && cur_count == '0;
            end
        end
    end

    // next ring pointers of the addressed user
    always_comb begin
        work_head_next  = cur_head;
        work_count_next = cur_count;
        ring_we         = 1'b0;
        if (cmd.apply && in_range && is_add) begin
            work_head_next  = add_head;
            work_count_next = add_count + 1'b1;
            ring_we         = 1'b1;
        end
        if (cmd.pop) begin
            work_head_next  = wrap_add(cur_head, RCntW'(1));
            work_count_next = cur_count - 1'b1;
            ring_we         = 1'b1;
        end
        if (do_erase) begin
            work_head_next  = '0;
            work_count_next = '0;
            ring_we         = 1'b1;
        end
    end

    // working copy of the pointers for the transaction in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_head_reg  <= '0;
            work_count_reg <= '0;
        end else begin
            work_head_reg  <= work_head_next;
            work_count_reg <= work_count_next;
        end
    end

    // pointer memory: read on accept, written back on every update
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot] <= {work_head_next, work_count_next};
        end
        if (cmd.load) begin
            ring_rd_reg <= ring_mem[in_slot];
        end
    end

    // present flags and user count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            total_reg   <= '0;
        end else begin
            if (cmd.apply && in_range && is_add && !cur_present) begin
                present_reg[slot] <= 1'b1;
                total_reg         <= total_reg + 1'b1;
            end
            if (do_erase && cur_present) begin
                present_reg[slot] <= 1'b0;
                total_reg         <= total_reg - 1'b1;
            end
        end
    end

    // removed flag for the status
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            removed_reg <= 1'b0;
        end else if (cmd.apply && do_erase && mode_reg == ModeRmEmpty) begin
            removed_reg <= 1'b1;
        end
    end

    // result formatting: user, zone, removed, count, total, pad
    logic [CntW-1:0] st_count;
    assign st_count = (in_range && cur_present) ? CntW'(cur_count) : '0;
    always_comb begin
        if (cmd.status) begin
            out_data = {4'd0, total_reg, st_count, removed_reg, 16'd0, user_reg};
            out_kind = 1'b1;
            out_last = 1'b1;
        end else begin
            out_data = {4'd0, 7'd0, 6'd0, 1'b0, rd_zone_reg, user_reg};
            out_kind = 1'b0;
            out_last = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/per_user_event_window_expiry.sv =====
// ----------------------------------------------------------------------------
// per_user_event_window_expiry
// Per-user sliding time window of zone events with expiry reports.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser mode; tdata user_slot, zone_tag, now_seconds
//  m_axis   | out       | tuser kind; expiry reports then one status (tlast)
//  cfg      | in        | window_seconds (0), history_cap (1)
//
//  Remove, query and sweep of an absent user go idle, lookup, status; add
//  and sweep of a present user loop read, check, emit per expired event,
//  then read, check, finish, paced by registered pointer and event reads.
//  Reset is synchronous and clears the present flags and the user count;
//  ring pointers of an absent user read as empty.
//  Output stalls hold the controller; no input is taken until the status goes.
// ----------------------------------------------------------------------------
module per_user_event_window_expiry #(
    parameter int USER_SLOTS    = puewe_pkg::UserSlotsDef,
    parameter int HISTORY_DEPTH = puewe_pkg::HistoryDepthDef
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // user_slot[5:0], zone_tag[21:6], now_seconds[53:22]
    input  logic [puewe_pkg::InDataW-1:0]     s_axis_tdata,
    // mode[2:0]
    input  logic [puewe_pkg::InUserW-1:0]     s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // out_user[5:0], out_zone[21:6], was_removed[22],
    // user_event_count[28:23], tracked_users[35:29]
    output logic [puewe_pkg::OutDataW-1:0]    m_axis_tdata,
    // kind[0]
    output logic [puewe_pkg::OutUserW-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [puewe_pkg::CfgIdxW-1:0]     cfg_addr,
    input  logic [puewe_pkg::WinW-1:0]        cfg_wdata
);
    import puewe_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer
    puewe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath
    puewe_dp #(
        .USER_SLOTS    (USER_SLOTS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_axis_tdata),
        .in_mode  (s_axis_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_addr),
        .cfg_data (cfg_wdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_axis_tdata),
        .out_kind (m_axis_tuser),
        .out_last (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/puewe_checker.sv =====
// ----------------------------------------------------------------------------
// puewe_checker
// Port-level checks for the per-user event window block.
// ----------------------------------------------------------------------------
module puewe_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic                                m_axis_tlast,
    input logic [puewe_pkg::OutUserW-1:0]      m_axis_tuser,
    input logic [puewe_pkg::OutDataW-1:0]      m_axis_tdata
);
    // one transaction in flight: no input taken while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // input acceptance leads to no result in the next cycle
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result right after accept");

    // tlast flags the status kind
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
        else $error("tlast does not match kind");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind per_user_event_window_expiry puewe_checker u_puewe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/event_window_checker.sv =====
// ----------------------------------------------------------------------------
// event_window_checker
// Watches the input, result and register-write channels of the per-user
// event window block, keeps its own copy of the per-user event rings and
// compares every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module event_window_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [puewe_pkg::InDataW-1:0]   s_tdata,
    input  logic [puewe_pkg::InUserW-1:0]   s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [puewe_pkg::OutDataW-1:0]  m_tdata,
    input  logic [puewe_pkg::OutUserW-1:0]  m_tuser,
    input  logic                            m_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [puewe_pkg::CfgIdxW-1:0]   cfg_addr,
    input  logic [puewe_pkg::WinW-1:0]      cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import puewe_pkg::*;

    localparam int Slots = UserSlotsDef;
    localparam int Depth = HistoryDepthDef;

    typedef struct packed {
        logic            kind;
        logic [UserW-1:0] user;
        logic [ZoneW-1:0] zone;
        logic            removed;
        logic [CntW-1:0] count;
        logic [TotW-1:0] total;
        logic            last;
    } window_result_t;

    window_result_t result_queue[$];

    logic [WinW-1:0]  window_secs;
    logic [CapW-1:0]  keep_cap;
    logic             present[Slots];
    logic [4:0]       head[Slots];
    logic [5:0]       fill[Slots];
    logic [ZoneW-1:0] zone_mem[Slots][Depth];
    logic [TimeW-1:0] stamp_mem[Slots][Depth];
    logic [TotW-1:0]  users_present;

    assign pending = result_queue.size();

    // append one expected result at the tail
    function automatic void queue_result(input window_result_t r);
        result_queue.insert(result_queue.size(), r);
    endfunction

    function automatic window_result_t report(input logic [UserW-1:0] u,
                                              input logic [ZoneW-1:0] z);
        window_result_t r;
        r = '0;
        r.user = u;
        r.zone = z;
        return r;
    endfunction

    // pop expired events off the front of one ring
    task automatic expire_old(input int u, input logic [TimeW-1:0] now);
        logic [TimeW-1:0] age;
        while (fill[u] > 0) begin
            age = now - stamp_mem[u][head[u]];
            if (age <= TimeW'(window_secs)) break;
            queue_result(report(UserW'(u), zone_mem[u][head[u]]));
            head[u] = head[u] + 5'd1;
            fill[u] = fill[u] - 6'd1;
        end
    endtask

    task automatic drop_user(input int u);
        if (present[u]) begin
            present[u] = 1'b0;
            users_present = users_present - 7'd1;
        end
        head[u] = '0;
        fill[u] = '0;
    endtask

    task automatic predict_item(input logic [InDataW-1:0] d, input logic [InUserW-1:0] tu);
        logic [ModeW-1:0] mode;
        int               u;
        logic [ZoneW-1:0] zone;
        logic [TimeW-1:0] now;
        int               cap;
        logic             removed;
        window_result_t   st;
        mode    = tu;
        u       = int'(d[5:0]);
        zone    = d[21:6];
        now     = d[53:22];
        cap     = int'(keep_cap);
        removed = 1'b0;
        if (cap == 0) cap = 1;
        if (cap > Depth) cap = Depth;
        case (mode)
            ModeAdd: begin
                if (!present[u]) begin
                    present[u] = 1'b1;
                    users_present = users_present + 7'd1;
                end
                while (int'(fill[u]) >= cap) begin
                    head[u] = head[u] + 5'd1;
                    fill[u] = fill[u] - 6'd1;
                end
                zone_mem[u][5'(head[u] + fill[u])]  = zone;
                stamp_mem[u][5'(head[u] + fill[u])] = now;
                fill[u] = fill[u] + 6'd1;
                expire_old(u, now);
            end
            ModeSweep: begin
                if (present[u]) begin
                    expire_old(u, now);
                    if (fill[u] == 0) drop_user(u);
                end
            end
            ModeRmEmpty: begin
                if (present[u] && fill[u] == 0) begin
                    drop_user(u);
                    removed = 1'b1;
                end
            end
            ModeRmUser: drop_user(u);
            default: ;
        endcase
        st = '0;
        st.kind    = 1'b1;
        st.user    = UserW'(u);
        st.removed = removed;
        st.count   = present[u] ? fill[u] : '0;
        st.total   = users_present;
        st.last    = 1'b1;
        queue_result(st);
    endtask

    task automatic compare_result(input logic [OutDataW-1:0] d, input logic [OutUserW-1:0] tu,
                                  input logic tl);
        window_result_t got;
        window_result_t exp_r;
        got.kind    = tu[0];
        got.user    = d[5:0];
        got.zone    = d[21:6];
        got.removed = d[22];
        got.count   = d[28:23];
        got.total   = d[35:29];
        got.last    = tl;
        if (result_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result transaction: %p", got);
        end else begin
            exp_r = result_queue[0];
            result_queue.delete(0);
            if (got !== exp_r || d[39:36] !== '0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result mismatch: expected %p, got %p (tdata %h)",
                             exp_r, got, d);
            end
        end
    endtask

    // model state follows reset, register writes and both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            window_secs   <= WindowReset;
            keep_cap      <= CapReset;
            users_present = '0;
            for (int i = 0; i < Slots; i++) begin
                present[i] = 1'b0;
                head[i]    = '0;
                fill[i]    = '0;
            end
            result_queue.delete();
        end else begin
            if (m_tvalid && m_tready) compare_result(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready) predict_item(s_tdata, s_tuser);
            if (cfg_we) begin
                if (cfg_addr == CfgWindow) window_secs <= cfg_wdata;
                else keep_cap <= cfg_wdata[CapW-1:0];
            end
        end
    end

    initial fail_count = 0;
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Regression for the per-user event window block: directed corner items,
// then random add/sweep/remove traffic over several register settings, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import puewe_pkg::*;

    localparam int StallLimit = 20000;
    localparam logic [ModeW-1:0] ModeQuery      = 3'd4;
    localparam logic [ModeW-1:0] ModeSpareFirst = 3'd5;
    localparam logic [ModeW-1:0] ModeSpareLast  = 3'd7;

    logic                aclk;
    logic                aresetn;
    logic [InDataW-1:0]  s_axis_tdata;
    logic [InUserW-1:0]  s_axis_tuser;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;
    logic                m_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_addr;
    logic [WinW-1:0]     cfg_wdata;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles;
    logic [TimeW-1:0]    clock_secs;

    per_user_event_window_expiry dut (.*);

    event_window_checker checker_i (
        .aclk, .aresetn,
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser), .s_tvalid(s_axis_tvalid),
        .s_tready(s_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser), .m_tlast(m_axis_tlast),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .cfg_we, .cfg_addr, .cfg_wdata,
        .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random result-side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if ($urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit) begin
            $display("per_user_event_window_expiry regression: fail");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic [ModeW-1:0] mode, input logic [UserW-1:0] u,
                             input logic [ZoneW-1:0] zone, input logic [TimeW-1:0] now);
        s_axis_tdata  <= {2'd0, now, zone, u};
        s_axis_tuser  <= mode;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk iff s_axis_tready);
        if (gap_len() != 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= InDataW'({$urandom, $urandom});
            s_axis_tuser  <= ModeW'($urandom);
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WinW-1:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly a clock creeping forward, sometimes a leap past the window
    task automatic random_phase(input int items, input int users);
        logic [ModeW-1:0] mode;
        int               r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) mode = ModeAdd;
            else if (r < 75) mode = ModeSweep;
            else if (r < 83) mode = ModeRmEmpty;
            else if (r < 90) mode = ModeRmUser;
            else mode = ModeW'($urandom_range(int'(ModeQuery), int'(ModeSpareLast)));
            r = $urandom_range(0, 99);
            if (r < 70) clock_secs = clock_secs + $urandom_range(0, 40);
            else if (r < 95) clock_secs = clock_secs + $urandom_range(0, 1200);
            else clock_secs = clock_secs + $urandom;
            send_item(mode, UserW'($urandom_range(0, users - 1)), ZoneW'($urandom),
                      clock_secs);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = CfgWindow;
        cfg_wdata     = '0;
        idle_cycles   = 0;
        clock_secs    = 32'hFFFF_FF00;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every named mode, extreme slots, zones, wrap of time
        send_item(ModeQuery, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ModeSweep, 6'd0, '0, '0);
        send_item(ModeRmEmpty, 6'd0, '0, '0);
        send_item(ModeRmUser, 6'd5, '0, '0);
        send_item(ModeAdd, 6'd0, 16'h0000, 32'hFFFF_FFF0);
        send_item(ModeAdd, 6'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ModeAdd, 6'd63, 16'hA5A5, 32'h0000_0010);
        send_item(ModeSweep, 6'd0, '0, 32'h0000_0200);
        send_item(ModeRmEmpty, 6'd63, '0, '0);
        send_item(ModeAdd, 6'd1, 16'h1234, 32'd1000);
        send_item(ModeAdd, 6'd1, 16'h5678, 32'd1300);
        send_item(ModeAdd, 6'd1, 16'h9ABC, 32'd1301);
        send_item(ModeSweep, 6'd1, '0, 32'd1602);
        send_item(ModeRmEmpty, 6'd1, '0, '0);
        send_item(ModeSweep, 6'd1, '0, 32'd9000);
        send_item(ModeRmEmpty, 6'd63, '0, '0);
        send_item(ModeSpareFirst, 6'd63, '0, '0);
        send_item(ModeSpareLast, 6'd2, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ModeRmUser, 6'd63, '0, '0);

        // tiny window and cap, drops and expiries stress the ring
        write_reg(CfgWindow, 16'd0);
        write_reg(CfgCap, 16'd0);
        send_item(ModeAdd, 6'd7, 16'h0001, 32'd5);
        send_item(ModeAdd, 6'd7, 16'h0002, 32'd6);
        clock_secs = 32'd100;
        random_phase(60, 4);

        write_reg(CfgWindow, 16'd50);
        write_reg(CfgCap, 16'd3);
        random_phase(90, 6);

        write_reg(CfgWindow, 16'hFFFF);
        write_reg(CfgCap, 16'd63);
        random_phase(80, 8);

        write_reg(CfgWindow, 16'd600);
        write_reg(CfgCap, 16'd32);
        random_phase(90, 64);

        write_reg(CfgWindow, 16'd1);
        write_reg(CfgCap, 16'd33);
        random_phase(80, 3);

        s_axis_tvalid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("per_user_event_window_expiry regression: pass");
        else
            $display("per_user_event_window_expiry regression: fail");
        $finish;
    end
endmodule
